>>> hdl/accumulator_machine_step_defines.svh
// Assertion macros used by the accumulator machine checker.
`ifndef ACCUMULATOR_MACHINE_STEP_DEFINES_SVH
`define ACCUMULATOR_MACHINE_STEP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define AMS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define AMS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ams_pkg.sv
// Types, constants and the microcode table of the accumulator machine.
`timescale 1ns / 1ps

package ams_pkg;

   // Fixed sizes of the machine and of its ports.
   localparam int MEM_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int OPC_BITS  = 3;
   localparam int ACTION_W  = 2;
   localparam int IN_WORD_W = 32;
   localparam int CHAR_W    = 8;

   typedef logic [ADDR_W-1:0] addr_type;

   // Input actions.
   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE   = 2'd0,
      ACT_EXEC    = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   // Instruction opcodes held in the low bits of a word.
   typedef enum logic [OPC_BITS-1:0] {
      OPC_END  = 3'd0,
      OPC_SKIP = 3'd1,
      OPC_ADD  = 3'd2,
      OPC_SUB  = 3'd3,
      OPC_LOAD = 3'd4,
      OPC_JUMP = 3'd5,
      OPC_JZ   = 3'd6,
      OPC_DRAW = 3'd7
   } opc_type;

   // Microprogram addresses.
   typedef enum logic [3:0] {
      UA_CLEAR    = 4'd0,
      UA_IDLE     = 4'd1,
      UA_WRITE    = 4'd2,
      UA_RESPOND  = 4'd3,
      UA_RESTART  = 4'd4,
      UA_FETCH    = 4'd5,
      UA_OPERAND  = 4'd6,
      UA_OP_END   = 4'd7,
      UA_OP_SKIP  = 4'd8,
      UA_OP_ADD   = 4'd9,
      UA_OP_SUB   = 4'd10,
      UA_OP_LOAD  = 4'd11,
      UA_OP_JUMP  = 4'd12,
      UA_OP_JZ    = 4'd13,
      UA_OP_DRAW  = 4'd14
   } uaddr_type;

   // Sequencing codes of a control word.
   typedef enum logic [2:0] {
      SEQ_GOTO        = 3'd0,
      SEQ_LOOP_CLR    = 3'd1,
      SEQ_IDLE        = 3'd2,
      SEQ_BR_HALT     = 3'd3,
      SEQ_DISPATCH_OP = 3'd4,
      SEQ_RESPOND     = 3'd5
   } seq_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_op_type;

   typedef enum logic [2:0] {
      ADR_CLR        = 3'd0,
      ADR_WADDR      = 3'd1,
      ADR_IP         = 3'd2,
      ADR_OPND_RDATA = 3'd3,
      ADR_OPND_REG   = 3'd4
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO  = 2'd0,
      WD_WWORD = 2'd1,
      WD_SUM   = 2'd2,
      WD_DIFF  = 2'd3
   } wdata_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD  = 2'd0,
      ACC_CLEAR = 2'd1,
      ACC_LOAD  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      IP_HOLD  = 3'd0,
      IP_INCR  = 3'd1,
      IP_JUMP  = 3'd2,
      IP_JZ    = 3'd3,
      IP_START = 3'd4
   } ip_op_type;

   typedef enum logic [1:0] {
      HALT_HOLD  = 2'd0,
      HALT_SET   = 2'd1,
      HALT_CLEAR = 2'd2
   } halt_op_type;

   // One microcode control word.
   typedef struct packed {
      mem_op_type    mem_op;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          opnd_load;
      acc_op_type    acc_op;
      ip_op_type     ip_op;
      halt_op_type   halt_op;
      logic          emit;
      seq_type       seq;
      uaddr_type     nxt;
   } ctl_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      ctl_type  cw;
      logic     take;
      logic     rsp_load;
      addr_type clr_addr;
      logic     idle;
   } seq_out_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic    halted;
      opc_type opcode;
   } dp_stat_type;

   // One result item.
   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_code;
      logic              halted;
      addr_type          pointer;
   } rsp_type;

   localparam ctl_type CTL_NOP = '{
      mem_op:    MEM_NONE,
      addr_sel:  ADR_IP,
      wdata_sel: WD_ZERO,
      opnd_load: 1'b0,
      acc_op:    ACC_HOLD,
      ip_op:     IP_HOLD,
      halt_op:   HALT_HOLD,
      emit:      1'b0,
      seq:       SEQ_GOTO,
      nxt:       UA_IDLE
   };

   // The microprogram. Each step that ends an item waits in SEQ_RESPOND until the
   // output register can take its result; its effects happen only on that cycle.
   function automatic ctl_type ucode_rom(input uaddr_type ua);
      ctl_type w;
      w = CTL_NOP;
      case (ua)
         UA_CLEAR: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADR_CLR;
            w.wdata_sel = WD_ZERO;
            w.seq       = SEQ_LOOP_CLR;
            w.nxt       = UA_IDLE;
         end
         UA_IDLE: begin
            w.seq = SEQ_IDLE;
         end
         UA_WRITE: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADR_WADDR;
            w.wdata_sel = WD_WWORD;
            w.seq       = SEQ_RESPOND;
         end
         UA_RESPOND: begin
            w.seq = SEQ_RESPOND;
         end
         UA_RESTART: begin
            w.ip_op   = IP_START;
            w.acc_op  = ACC_CLEAR;
            w.halt_op = HALT_CLEAR;
            w.seq     = SEQ_RESPOND;
         end
         UA_FETCH: begin
            w.mem_op   = MEM_READ;
            w.addr_sel = ADR_IP;
            w.seq      = SEQ_BR_HALT;
            w.nxt      = UA_OPERAND;
         end
         UA_OPERAND: begin
            w.mem_op    = MEM_READ;
            w.addr_sel  = ADR_OPND_RDATA;
            w.opnd_load = 1'b1;
            w.seq       = SEQ_DISPATCH_OP;
         end
         UA_OP_END: begin
            w.halt_op = HALT_SET;
            w.seq     = SEQ_RESPOND;
         end
         UA_OP_SKIP: begin
            w.ip_op = IP_INCR;
            w.seq   = SEQ_RESPOND;
         end
         UA_OP_ADD: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADR_OPND_REG;
            w.wdata_sel = WD_SUM;
            w.ip_op     = IP_INCR;
            w.seq       = SEQ_RESPOND;
         end
         UA_OP_SUB: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADR_OPND_REG;
            w.wdata_sel = WD_DIFF;
            w.ip_op     = IP_INCR;
            w.seq       = SEQ_RESPOND;
         end
         UA_OP_LOAD: begin
            w.acc_op = ACC_LOAD;
            w.ip_op  = IP_INCR;
            w.seq    = SEQ_RESPOND;
         end
         UA_OP_JUMP: begin
            w.ip_op = IP_JUMP;
            w.seq   = SEQ_RESPOND;
         end
         UA_OP_JZ: begin
            w.ip_op = IP_JZ;
            w.seq   = SEQ_RESPOND;
         end
         UA_OP_DRAW: begin
            w.emit  = 1'b1;
            w.ip_op = IP_INCR;
            w.seq   = SEQ_RESPOND;
         end
         default: begin
            w = CTL_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hdl/accumulator_machine_step.sv
// Top level of the accumulator machine: sequencer, datapath and result register.
`timescale 1ns / 1ps

// Each request transfer loads a program word, executes one instruction or restarts at
// csr_write_data's start address, and yields exactly one response transfer. The control
// is a small microprogram on a single-port program RAM, so an execute goes through the
// steps request, fetch read, operand read, execute with write-back; a load, a restart or
// an undefined action has only the request and result steps, an execute while halted the
// request, fetch read and result. The next request is taken as soon as the result sits in
// the output register, even if it is still stalled there. After reset the RAM is cleared
// one word per cycle through all 1024 words, during which req_stall stays high; the start
// address may be written at any time through csr_write_enable.

module accumulator_machine_step #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ams_pkg::ACTION_W-1:0]         req_action,
   input  logic [ams_pkg::ADDR_W-1:0]           req_write_address,
   input  logic signed [ams_pkg::IN_WORD_W-1:0] req_write_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_char_valid,
   output logic [ams_pkg::CHAR_W-1:0]           rsp_char_code,
   output logic                                 rsp_halted,
   output logic [ams_pkg::ADDR_W-1:0]           rsp_pointer,
   input  logic                                 csr_write_enable,
   input  logic [ams_pkg::ADDR_W-1:0]           csr_write_data
);

   ams_pkg::seq_out_type sq;
   ams_pkg::dp_stat_type stat;
   ams_pkg::rsp_type     result;
   ams_pkg::rsp_type     rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   // The output register can load when empty or when its content transfers now.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = sq.rsp_load || (rsp_valid_ff && rsp_stall);
   assign req_stall    = !sq.idle;

   ams_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .out_free   (out_free),
      .stat       (stat),
      .sq         (sq)
   );

   ams_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .sq                (sq),
      .req_write_address (req_write_address),
      .req_write_word    (req_write_word),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .stat              (stat),
      .result            (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq.rsp_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_valid = rsp_ff.char_valid;
   assign rsp_char_code  = rsp_ff.char_code;
   assign rsp_halted     = rsp_ff.halted;
   assign rsp_pointer    = rsp_ff.pointer;

endmodule

>>> hdl/ams_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module ams_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access a cycle; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end else if (en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ams_sequencer.sv
// Microprogram counter, control store and branch logic of the accumulator machine.
`timescale 1ns / 1ps

module ams_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [ams_pkg::ACTION_W-1:0]    req_action,
   input  logic                            out_free,
   input  ams_pkg::dp_stat_type            stat,
   output ams_pkg::seq_out_type            sq
);

   ams_pkg::uaddr_type upc_ff, upc_in;
   ams_pkg::addr_type  clr_ff, clr_in;
   ams_pkg::ctl_type   cw;
   logic               fire;

   assign cw = ams_pkg::ucode_rom(upc_ff);

   // A step that ends an item acts only when the output register is free.
   assign fire = (cw.seq != ams_pkg::SEQ_RESPOND) || out_free;

   // Next microprogram address and clear counter.
   always_comb begin
      upc_in = upc_ff;
      clr_in = clr_ff;
      case (cw.seq)
         ams_pkg::SEQ_GOTO: begin
            upc_in = cw.nxt;
         end
         ams_pkg::SEQ_LOOP_CLR: begin
            clr_in = clr_ff + ams_pkg::ADDR_W'(1);
            if (clr_ff == ams_pkg::ADDR_W'(ams_pkg::MEM_DEPTH - 1)) begin
               upc_in = cw.nxt;
            end
         end
         ams_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               case (ams_pkg::action_type'(req_action))
                  ams_pkg::ACT_WRITE:   upc_in = ams_pkg::UA_WRITE;
                  ams_pkg::ACT_EXEC:    upc_in = ams_pkg::UA_FETCH;
                  ams_pkg::ACT_RESTART: upc_in = ams_pkg::UA_RESTART;
                  default:              upc_in = ams_pkg::UA_RESPOND;
               endcase
            end
         end
         ams_pkg::SEQ_BR_HALT: begin
            upc_in = stat.halted ? ams_pkg::UA_RESPOND : cw.nxt;
         end
         ams_pkg::SEQ_DISPATCH_OP: begin
            case (stat.opcode)
               ams_pkg::OPC_END:  upc_in = ams_pkg::UA_OP_END;
               ams_pkg::OPC_SKIP: upc_in = ams_pkg::UA_OP_SKIP;
               ams_pkg::OPC_ADD:  upc_in = ams_pkg::UA_OP_ADD;
               ams_pkg::OPC_SUB:  upc_in = ams_pkg::UA_OP_SUB;
               ams_pkg::OPC_LOAD: upc_in = ams_pkg::UA_OP_LOAD;
               ams_pkg::OPC_JUMP: upc_in = ams_pkg::UA_OP_JUMP;
               ams_pkg::OPC_JZ:   upc_in = ams_pkg::UA_OP_JZ;
               default:           upc_in = ams_pkg::UA_OP_DRAW;
            endcase
         end
         ams_pkg::SEQ_RESPOND: begin
            if (out_free) begin
               upc_in = ams_pkg::UA_IDLE;
            end
         end
         default: begin
            upc_in = ams_pkg::UA_IDLE;
         end
      endcase
   end

   // Control toward the datapath, with state changes held back while waiting.
   always_comb begin
      sq.cw = cw;
      if (!fire) begin
         sq.cw.mem_op    = ams_pkg::MEM_NONE;
         sq.cw.opnd_load = 1'b0;
         sq.cw.acc_op    = ams_pkg::ACC_HOLD;
         sq.cw.ip_op     = ams_pkg::IP_HOLD;
         sq.cw.halt_op   = ams_pkg::HALT_HOLD;
      end
      sq.take     = (cw.seq == ams_pkg::SEQ_IDLE) && req_valid;
      sq.rsp_load = (cw.seq == ams_pkg::SEQ_RESPOND) && out_free;
      sq.clr_addr = clr_ff;
      sq.idle     = (cw.seq == ams_pkg::SEQ_IDLE);
   end

   // The program starts with the memory clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ams_pkg::UA_CLEAR;
         clr_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         clr_ff <= clr_in;
      end
   end

endmodule

>>> hdl/ams_datapath.sv
// Registers, program memory and arithmetic of the accumulator machine.
`timescale 1ns / 1ps

module ams_datapath #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ams_pkg::seq_out_type                sq,
   input  logic [ams_pkg::ADDR_W-1:0]          req_write_address,
   input  logic signed [ams_pkg::IN_WORD_W-1:0] req_write_word,
   input  logic                                csr_write_enable,
   input  logic [ams_pkg::ADDR_W-1:0]          csr_write_data,
   output ams_pkg::dp_stat_type                stat,
   output ams_pkg::rsp_type                    result
);

   ams_pkg::addr_type                  waddr_ff;
   logic signed [ams_pkg::IN_WORD_W-1:0] wword_ff;
   ams_pkg::addr_type                  opnd_ff, opnd_in;
   logic [WORD_WIDTH-1:0]              acc_ff, acc_in;
   ams_pkg::addr_type                  ip_ff, ip_in;
   logic                               halt_ff, halt_in;
   ams_pkg::addr_type                  start_ff, start_in;

   logic                  mem_en;
   logic                  mem_we;
   ams_pkg::addr_type     mem_addr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic [WORD_WIDTH-1:0] mem_rdata;
   ams_pkg::addr_type     opnd_rdata;
   ams_pkg::addr_type     ip_step;

   // The operand address is the word shifted right by the opcode bits, wrapped.
   assign opnd_rdata = mem_rdata[ams_pkg::OPC_BITS +: ams_pkg::ADDR_W];
   assign ip_step    = ip_ff + ams_pkg::ADDR_W'(1);

   // Memory port control and address selection.
   always_comb begin
      mem_en = (sq.cw.mem_op != ams_pkg::MEM_NONE);
      mem_we = (sq.cw.mem_op == ams_pkg::MEM_WRITE);
      case (sq.cw.addr_sel)
         ams_pkg::ADR_CLR:        mem_addr = sq.clr_addr;
         ams_pkg::ADR_WADDR:      mem_addr = waddr_ff;
         ams_pkg::ADR_IP:         mem_addr = ip_ff;
         ams_pkg::ADR_OPND_RDATA: mem_addr = opnd_rdata;
         ams_pkg::ADR_OPND_REG:   mem_addr = opnd_ff;
         default:                 mem_addr = ip_ff;
      endcase
   end

   // Write data: cleared word, loaded word, or the operand updated by the accumulator.
   always_comb begin
      case (sq.cw.wdata_sel)
         ams_pkg::WD_ZERO:  mem_wdata = '0;
         ams_pkg::WD_WWORD: mem_wdata = WORD_WIDTH'(wword_ff);
         ams_pkg::WD_SUM:   mem_wdata = mem_rdata + acc_ff;
         ams_pkg::WD_DIFF:  mem_wdata = mem_rdata - acc_ff;
         default:           mem_wdata = '0;
      endcase
   end

   // Next values of the architectural registers.
   always_comb begin
      opnd_in = sq.cw.opnd_load ? opnd_rdata : opnd_ff;

      case (sq.cw.acc_op)
         ams_pkg::ACC_CLEAR: acc_in = '0;
         ams_pkg::ACC_LOAD:  acc_in = mem_rdata;
         default:            acc_in = acc_ff;
      endcase

      case (sq.cw.ip_op)
         ams_pkg::IP_INCR:  ip_in = ip_step;
         ams_pkg::IP_JUMP:  ip_in = opnd_ff;
         ams_pkg::IP_JZ:    ip_in = (acc_ff == '0) ? opnd_ff : ip_step;
         ams_pkg::IP_START: ip_in = start_ff;
         default:           ip_in = ip_ff;
      endcase

      case (sq.cw.halt_op)
         ams_pkg::HALT_SET:   halt_in = 1'b1;
         ams_pkg::HALT_CLEAR: halt_in = 1'b0;
         default:             halt_in = halt_ff;
      endcase

      start_in = csr_write_enable ? csr_write_data : start_ff;
   end

   // Status for branching and the result that the current step reports.
   always_comb begin
      stat.halted       = halt_ff;
      stat.opcode       = ams_pkg::opc_type'(mem_rdata[ams_pkg::OPC_BITS-1:0]);
      result.char_valid = sq.cw.emit;
      result.char_code  = sq.cw.emit ? mem_rdata[ams_pkg::CHAR_W-1:0] : '0;
      result.halted     = halt_in;
      result.pointer    = ip_in;
   end

   // Machine state and the start address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         ip_ff    <= '0;
         halt_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         ip_ff    <= ip_in;
         halt_ff  <= halt_in;
         start_ff <= start_in;
      end
   end

   // Fields of the accepted item and the operand address of the instruction.
   always_ff @(posedge clock) begin
      if (sq.take) begin
         waddr_ff <= req_write_address;
         wword_ff <= req_write_word;
      end
      opnd_ff <= opnd_in;
   end

   ams_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (ams_pkg::MEM_DEPTH)
   ) u_program_ram (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

>>> hdl/ams_checker.sv
// Port-level assertions for the accumulator machine, bound to its top level.
`timescale 1ns / 1ps
`include "accumulator_machine_step_defines.svh"

module ams_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_char_valid,
   input logic [ams_pkg::CHAR_W-1:0] rsp_char_code,
   input logic                       rsp_halted,
   input logic [ams_pkg::ADDR_W-1:0] rsp_pointer
);

   // No result is shown in the cycle after reset.
   `AMS_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_valid, "result after reset")

   // A request transfer always sends the sequencer out of its idle step, which raises req_stall.
   `AMS_ASSERT_RST(a_busy_after_req, clock, reset, req_valid && !req_stall |=> req_stall, "request taken twice in a row")

   // Without a drawn character the code field is zero.
   `AMS_ASSERT_RST(a_char_code_zero, clock, reset, rsp_valid && !rsp_char_valid |-> rsp_char_code == '0, "char code without char")

   // A stalled result holds.
   `AMS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_valid) && $stable(rsp_char_code) && $stable(rsp_halted) && $stable(rsp_pointer), "stalled result changed")

endmodule

bind accumulator_machine_step ams_checker u_ams_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_char_valid (rsp_char_valid),
   .rsp_char_code  (rsp_char_code),
   .rsp_halted     (rsp_halted),
   .rsp_pointer    (rsp_pointer)
);
